// ===== src/tde_pkg.sv =====
// tde_pkg: shared constants and types of the trigram distinct extractor
// used by the channel interfaces and every module of the block except tde_ram
package tde_pkg;

   // slot table and hash
   localparam int TABLE_SLOTS_DEF = 8192;
   localparam logic [31:0] GOLDEN_MUL = 32'h9E37_79B9;
   localparam int HASH_W = 16;          // widest slot index the table may need
   localparam int KEY_W = 24;
   localparam int BYTE_W = 8;

   // per-record counter and cap register
   localparam int CNT_W = 13;
   localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

   // record generation tag stored with each slot; zero marks a free slot
   localparam int EPOCH_W = 8;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // classified item handed from front to back
   typedef struct packed {
      logic              window_ok;
      logic              first;
      logic              last;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hash;
   } tde_item_type;

   // one result item
   typedef struct packed {
      logic              tri_valid;
      logic [BYTE_W-1:0] tri_first;
      logic [BYTE_W-1:0] tri_second;
      logic [BYTE_W-1:0] tri_third;
      logic              record_end;
      logic [CNT_W-1:0]  distinct_count;
   } tde_result_type;

endpackage

// ===== src/tde_req_if.sv =====
// tde_req_if: input byte channel of the trigram extractor
// depends on tde_pkg for field widths
interface tde_req_if import tde_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              first_of_record;
   logic              last_of_record;

   modport source (output valid, data_byte, first_of_record, last_of_record, input ready);
   modport sink (input valid, data_byte, first_of_record, last_of_record, output ready);
endinterface

// ===== src/tde_rsp_if.sv =====
// tde_rsp_if: result channel of the trigram extractor
// depends on tde_pkg for field widths
interface tde_rsp_if import tde_pkg::*;;
   logic              valid;
   logic              ready;
   logic              tri_valid;
   logic [BYTE_W-1:0] tri_first;
   logic [BYTE_W-1:0] tri_second;
   logic [BYTE_W-1:0] tri_third;
   logic              record_end;
   logic [CNT_W-1:0]  distinct_count;

   modport source (output valid, tri_valid, tri_first, tri_second, tri_third, record_end,
                   distinct_count, input ready);
   modport sink (input valid, tri_valid, tri_first, tri_second, tri_third, record_end,
                 distinct_count, output ready);
endinterface

// ===== src/tde_ram.sv =====
// tde_ram: generic single write port, single read port ram with registered read
// no dependencies
module tde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== src/tde_front.sv =====
// tde_front: accepts bytes, folds case, tracks the three-byte window and hashes the key
// depends on tde_pkg and tde_req_if
module tde_front import tde_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   tde_req_if.sink      req,
   output logic         push_valid,
   output tde_item_type push_item,
   input  logic         push_ready
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam logic [IDX_W-1:0] GOLD_LO = GOLDEN_MUL[IDX_W-1:0];
   localparam logic [BYTE_W-1:0] UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;
   localparam logic [1:0] SEEN_FULL = 2'd2;

   logic [2*BYTE_W-1:0] prev_ff, prev_in;
   logic [1:0]          seen_ff, seen_in;

   logic [BYTE_W-1:0]   folded;
   logic [2*BYTE_W-1:0] prev_eff;
   logic [1:0]          seen_eff;
   logic [KEY_W-1:0]    key;
   logic [IDX_W-1:0]    prod;
   logic                accept;

   // fold ascii upper case to lower case
   assign folded = (req.data_byte >= UPPER_A && req.data_byte <= UPPER_Z) ?
                   req.data_byte + CASE_OFFSET : req.data_byte;

   // a first byte starts from an empty window
   assign prev_eff = req.first_of_record ? '0 : prev_ff;
   assign seen_eff = req.first_of_record ? '0 : seen_ff;
   assign key      = {prev_eff, folded};

   // only the low index bits of the product matter
   assign prod = key[IDX_W-1:0] * GOLD_LO;

   // handshake straight through to the queue
   assign push_valid = req.valid;
   assign req.ready  = push_ready;
   assign accept     = req.valid && push_ready;

   always_comb begin
      push_item.window_ok = (seen_eff == SEEN_FULL);
      push_item.first     = req.first_of_record;
      push_item.last      = req.last_of_record;
      push_item.key       = key;
      push_item.hash      = HASH_W'(prod);
   end

   // window update on accept
   always_comb begin
      prev_in = prev_ff;
      seen_in = seen_ff;
      if (accept) begin
         prev_in = {prev_eff[BYTE_W-1:0], folded};
         seen_in = (seen_eff == SEEN_FULL) ? SEEN_FULL : seen_eff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         seen_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         seen_ff <= seen_in;
      end
   end

endmodule

// ===== src/tde_queue.sv =====
// tde_queue: short fifo of classified items between front and back
// depends on tde_pkg
module tde_queue import tde_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  tde_item_type push_item,
   output logic         push_ready,
   output logic         pop_valid,
   output tde_item_type pop_item,
   input  logic         pop_ready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

   tde_item_type      entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = (fill_ff != FILL_FULL);
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/tde_back.sv =====
// tde_back: probes the slot table, counts distinct trigrams and drives the result register
// depends on tde_pkg, tde_rsp_if and tde_ram
module tde_back import tde_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data,
   input  logic             pop_valid,
   input  tde_item_type     pop_item,
   output logic             pop_ready,
   tde_rsp_if.source        rsp
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int RAM_W = EPOCH_W + KEY_W;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

   typedef enum logic [4:0] {
      S_SWEEP  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_START  = 5'b00100,
      S_PROBE  = 5'b01000,
      S_FINISH = 5'b10000
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   sweep_addr_ff, sweep_addr_in;
   logic               resume_ff, resume_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               stopped_ff, stopped_in;
   logic               emit_ff, emit_in;
   logic [CNT_W-1:0]   cap_ff, cap_in;
   tde_item_type       item_ff, item_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [IDX_W-1:0]   probe_n_ff, probe_n_in;
   logic               out_valid_ff, out_valid_in;
   tde_result_type     out_ff, out_in;

   logic               ram_we;
   logic [IDX_W-1:0]   wr_addr;
   logic [RAM_W-1:0]   wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [RAM_W-1:0]   rd_data;
   logic               slot_used, key_hit, out_free, out_load;
   logic [CNT_W-1:0]   count_inc;
   logic [IDX_W-1:0]   addr_next;
   tde_result_type     result;

   // slot table: record tag and key per slot
   tde_ram #(
      .WIDTH (RAM_W),
      .DEPTH (TABLE_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_used = (rd_data[RAM_W-1:KEY_W] == epoch_ff);
   assign key_hit   = (rd_data[KEY_W-1:0] == item_ff.key);
   assign count_inc = count_ff + CNT_W'(1);
   assign addr_next = addr_ff + IDX_W'(1);
   assign out_free  = !out_valid_ff || rsp.ready;

   // result fields; trigram bytes read as zero unless a trigram is carried
   always_comb begin
      result.tri_valid      = emit_ff;
      result.tri_first      = emit_ff ? item_ff.key[3*BYTE_W-1:2*BYTE_W] : '0;
      result.tri_second     = emit_ff ? item_ff.key[2*BYTE_W-1:BYTE_W] : '0;
      result.tri_third      = emit_ff ? item_ff.key[BYTE_W-1:0] : '0;
      result.record_end     = item_ff.last;
      result.distinct_count = count_ff;
   end

   // probe sequencer
   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      resume_in     = resume_ff;
      epoch_in      = epoch_ff;
      count_in      = count_ff;
      stopped_in    = stopped_ff;
      emit_in       = emit_ff;
      item_in       = item_ff;
      addr_in       = addr_ff;
      probe_n_in    = probe_n_ff;
      ram_we        = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = {epoch_ff, item_ff.key};
      rd_addr       = addr_ff;
      pop_ready     = 1'b0;
      out_load      = 1'b0;
      unique case (state_ff)
         S_SWEEP: begin
            // mark every slot free, one per cycle
            ram_we        = 1'b1;
            wr_addr       = sweep_addr_ff;
            wr_data       = '0;
            sweep_addr_in = sweep_addr_ff + IDX_W'(1);
            if (sweep_addr_ff == '1) begin
               epoch_in  = EPOCH_FIRST;
               resume_in = 1'b0;
               state_in  = resume_ff ? S_START : S_IDLE;
            end
         end
         S_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               item_in  = pop_item;
               emit_in  = 1'b0;
               state_in = S_START;
               // a new record gets a fresh tag, or a sweep once tags run out
               if (pop_item.first) begin
                  count_in   = '0;
                  stopped_in = 1'b0;
                  if (epoch_ff == EPOCH_LAST) begin
                     state_in      = S_SWEEP;
                     resume_in     = 1'b1;
                     sweep_addr_in = '0;
                  end else begin
                     epoch_in = epoch_ff + EPOCH_W'(1);
                  end
               end
            end
         end
         S_START: begin
            if (item_ff.window_ok && !stopped_ff) begin
               if (count_ff >= cap_ff) begin
                  stopped_in = 1'b1;
                  state_in   = S_FINISH;
               end else begin
                  rd_addr    = item_ff.hash[IDX_W-1:0];
                  addr_in    = item_ff.hash[IDX_W-1:0];
                  probe_n_in = '0;
                  state_in   = S_PROBE;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_PROBE: begin
            if (!slot_used) begin
               // free slot: insert and emit
               ram_we   = 1'b1;
               emit_in  = 1'b1;
               count_in = count_inc;
               if (count_inc >= cap_ff) begin
                  stopped_in = 1'b1;
               end
               state_in = S_FINISH;
            end else if (key_hit) begin
               state_in = S_FINISH;
            end else if (probe_n_ff == '1) begin
               // whole table visited without a free slot
               stopped_in = 1'b1;
               state_in   = S_FINISH;
            end else begin
               rd_addr    = addr_next;
               addr_in    = addr_next;
               probe_n_in = probe_n_ff + IDX_W'(1);
            end
         end
         S_FINISH: begin
            if (!(emit_ff || item_ff.last)) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register and cap register
   always_comb begin
      out_in       = out_load ? result : out_ff;
      out_valid_in = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
      cap_in       = csr_write_enable ? csr_write_data : cap_ff;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.tri_valid      = out_ff.tri_valid;
   assign rsp.tri_first      = out_ff.tri_first;
   assign rsp.tri_second     = out_ff.tri_second;
   assign rsp.tri_third      = out_ff.tri_third;
   assign rsp.record_end     = out_ff.record_end;
   assign rsp.distinct_count = out_ff.distinct_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         sweep_addr_ff <= '0;
         resume_ff     <= 1'b0;
         epoch_ff      <= '0;
         count_ff      <= '0;
         stopped_ff    <= 1'b0;
         emit_ff       <= 1'b0;
         cap_ff        <= CAP_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         resume_ff     <= resume_in;
         epoch_ff      <= epoch_in;
         count_ff      <= count_in;
         stopped_ff    <= stopped_in;
         emit_ff       <= emit_in;
         cap_ff        <= cap_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      addr_ff    <= addr_in;
      probe_n_ff <= probe_n_in;
      out_ff     <= out_in;
   end

   // a live record tag is never the free mark
   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SWEEP) |-> (epoch_ff != '0))
      else $error("record tag is zero outside a sweep");

   // the table is written only by the sweep or an insert
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_SWEEP || state_ff == S_PROBE))
      else $error("slot table written outside sweep or probe");

   // an emitted trigram has been counted
   a_emit_counted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && emit_ff) |-> (count_ff != '0))
      else $error("trigram emitted with zero count");

   // a loaded result shows on the channel next cycle
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (out_valid_ff && $past(result) == out_ff))
      else $error("loaded result not presented");

endmodule

// ===== src/trigram_distinct_extractor_unit.sv =====
// Distinct trigram extractor. Bytes of a record enter on req, are folded to lower case,
// and every new three-byte window is looked up by linear probing in a slot table of
// TABLE_SLOTS entries; a trigram seen for the first time in the record leaves on rsp
// until the count reaches the cap, and the last byte of a record always leaves a result
// with record_end and the count. The back end works on one byte at a time, in its start,
// probe and finish states, reading slots one per cycle from the single read port of the
// slot table. A two-entry queue lets the front keep taking bytes meanwhile. After reset,
// and once every 255 records, the back end marks all TABLE_SLOTS entries free; bytes
// queue up during that sweep. The cap register is written through csr_write_*.
module trigram_distinct_extractor_unit import tde_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   tde_req_if.sink          req,
   tde_rsp_if.source        rsp,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data
);

   logic         push_valid, push_ready;
   tde_item_type push_item;
   logic         pop_valid, pop_ready;
   tde_item_type pop_item;

   // byte intake and hashing
   tde_front #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // decoupling queue
   tde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // table probing and results
   tde_back #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pop_valid        (pop_valid),
      .pop_item         (pop_item),
      .pop_ready        (pop_ready),
      .rsp              (rsp)
   );

endmodule
